// ===== design/crsf_pkg.sv =====
// Shared types and constants for the CRSF frame decoder.
// Used by the CRC unit and the top level; depends on nothing else.
`timescale 1ns / 1ps

package crsf_pkg;

    localparam logic [7:0] SYNC_MAIN = 8'hC8;
    localparam logic [7:0] SYNC_ALT  = 8'hEE;
    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] TYPE_RC   = 8'h16;
    localparam logic [7:0] TYPE_BATT = 8'h08;
    localparam logic [7:0] TYPE_ATT  = 8'h1E;

    localparam int CH_BITS   = 11;
    localparam int NUM_CH    = 16;
    localparam int ACC_BITS  = 18;
    localparam int NBIT_BITS = 5;

    localparam logic [1:0] KIND_CHAN   = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_TYPE   = 2'd2;
    localparam logic [1:0] KIND_DESYNC = 2'd3;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_GATHER,
        ST_SKIP,
        ST_CRC,
        ST_FAIL,
        ST_NOTE,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef enum logic [1:0] {
        MD_RC,
        MD_BYTES,
        MD_PUT
    } t_mode;

    typedef struct packed {
        logic       clear;
        logic       start;
        logic [7:0] data;
    } t_crc_ctrl;

endpackage

// ===== design/crsf_crc_unit.sv =====
// Bit-serial CRC-8 (polynomial 0xD5) unit holding the running checksum.
// Each byte is XORed in on start and then shifted through bit by bit. Depends on crsf_pkg.
`timescale 1ns / 1ps

module crsf_crc_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crsf_pkg::t_crc_ctrl i_ctrl,
    output logic                o_busy,
    output logic [7:0]          o_crc
);

    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    always_comb begin
        n_crc = r_crc;
        n_cnt = r_cnt;
        if (i_ctrl.clear) begin
            n_crc = 8'd0;
            n_cnt = 4'd0;
        end else if (i_ctrl.start) begin
            n_crc = r_crc ^ i_ctrl.data;
            n_cnt = 4'd8;
        end else if (r_cnt != 4'd0) begin
            n_crc = r_crc[7] ? ({r_crc[6:0], 1'b0} ^ crsf_pkg::CRC_POLY)
                             : {r_crc[6:0], 1'b0};
            n_cnt = r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 8'd0;
            r_cnt <= 4'd0;
        end else begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
        end
    end

    assign o_busy = (r_cnt != 4'd0);
    assign o_crc  = r_crc;

endmodule

// ===== design/crsf_frame_store.sv =====
// Payload byte memory with one write port and one registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps

module crsf_frame_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/crsf_frame_decoder_unit.sv =====
// Each accepted beat on the receive side is one byte; the decoder hunts for a sync byte
// (0xC8 or 0xEE), gathers the frame, checks CRC-8 over type and payload, and sends RC
// channels, payload bytes, a type notice or a desync beat. Sync hunting and skipping take
// one cycle per byte. Each type or payload byte then stalls the input while the bit-serial
// CRC unit folds it in. Payload frames send each beat after a memory read and then an
// output load; RC frames make 22 reads and send 16 channel beats through one shift
// accumulator. Output stalls hold back each result beat.
// Depends on crsf_pkg, crsf_crc_unit and crsf_frame_store.
`timescale 1ns / 1ps

module crsf_frame_decoder_unit #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_frame_type,
    output logic [5:0]  o_item_index,
    output logic [10:0] o_item_value,
    output logic        o_last
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    crsf_pkg::t_state r_state;
    crsf_pkg::t_state n_state;
    crsf_pkg::t_mode  r_mode;
    crsf_pkg::t_mode  n_mode;

    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;
    logic [7:0]    r_len;
    logic [7:0]    n_len;
    logic [7:0]    r_type;
    logic [7:0]    n_type;
    logic [7:0]    r_idx;
    logic [7:0]    n_idx;
    logic [3:0]    r_ch;
    logic [3:0]    n_ch;
    logic [crsf_pkg::ACC_BITS-1:0]  r_acc;
    logic [crsf_pkg::ACC_BITS-1:0]  n_acc;
    logic [crsf_pkg::NBIT_BITS-1:0] r_nbits;
    logic [crsf_pkg::NBIT_BITS-1:0] n_nbits;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [1:0]  r_kind;
    logic [1:0]  n_kind;
    logic [7:0]  r_otype;
    logic [7:0]  n_otype;
    logic [5:0]  r_oidx;
    logic [5:0]  n_oidx;
    logic [10:0] r_oval;
    logic [10:0] n_oval;
    logic        r_olast;
    logic        n_olast;

    crsf_pkg::t_crc_ctrl w_crc_ctrl;
    logic                w_crc_busy;
    logic [7:0]          w_crc;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [7:0]          w_rdata;

    logic       w_rx_acc;
    logic       w_out_free;
    logic       w_sync;
    logic [7:0] w_plen;
    logic [7:0] w_byte;
    logic       w_final;
    logic       w_bad_len;

    crsf_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_crc_ctrl),
        .o_busy  (w_crc_busy),
        .o_crc   (w_crc)
    );

    crsf_frame_store #(
        .DEPTH (MAX_FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_rx_stall = !(r_state == crsf_pkg::ST_HUNT || r_state == crsf_pkg::ST_GATHER ||
                          r_state == crsf_pkg::ST_SKIP);
    assign w_rx_acc   = i_rx_valid && !o_rx_stall;
    assign w_out_free = !r_out_valid || !i_res_stall;
    assign w_sync     = (i_rx_byte == crsf_pkg::SYNC_MAIN) || (i_rx_byte == crsf_pkg::SYNC_ALT);
    assign w_plen     = r_len - 8'd2;
    assign w_byte     = (r_idx < w_plen) ? w_rdata : 8'd0;
    assign w_final    = (9'(r_pos) == ({1'b0, r_len} + 9'd1));
    assign w_bad_len  = (i_rx_byte < 8'd2) || ({1'b0, i_rx_byte} > 9'(MAX_FRAME_BYTES - 2));
    assign w_waddr    = r_pos - AW'(3);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_len       = r_len;
        n_type      = r_type;
        n_idx       = r_idx;
        n_ch        = r_ch;
        n_acc       = r_acc;
        n_nbits     = r_nbits;
        n_out_valid = r_out_valid && i_res_stall;
        n_kind      = r_kind;
        n_otype     = r_otype;
        n_oidx      = r_oidx;
        n_oval      = r_oval;
        n_olast     = r_olast;
        w_crc_ctrl  = '{clear: 1'b0, start: 1'b0, data: i_rx_byte};
        w_we        = 1'b0;

        case (r_state)
            crsf_pkg::ST_HUNT: begin
                if (w_rx_acc && w_sync) begin
                    w_crc_ctrl.clear = 1'b1;
                    n_pos   = AW'(1);
                    n_state = crsf_pkg::ST_GATHER;
                end
            end
            crsf_pkg::ST_SKIP: begin
                if (w_rx_acc && w_sync) begin
                    n_state = crsf_pkg::ST_HUNT;
                end
            end
            crsf_pkg::ST_GATHER: begin
                if (w_rx_acc) begin
                    n_pos = r_pos + AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_len = i_rx_byte;
                        if (w_bad_len) begin
                            n_state = crsf_pkg::ST_FAIL;
                        end
                    end else if (r_pos == AW'(2)) begin
                        n_type           = i_rx_byte;
                        w_crc_ctrl.start = 1'b1;
                        n_state          = crsf_pkg::ST_CRC;
                    end else if (w_final) begin
                        n_idx   = 8'd0;
                        n_ch    = 4'd0;
                        n_acc   = '0;
                        n_nbits = '0;
                        if (w_crc != i_rx_byte) begin
                            n_state = crsf_pkg::ST_FAIL;
                        end else if (r_type == crsf_pkg::TYPE_RC) begin
                            n_mode  = crsf_pkg::MD_RC;
                            n_state = crsf_pkg::ST_READ;
                        end else if (r_type == crsf_pkg::TYPE_BATT ||
                                     r_type == crsf_pkg::TYPE_ATT || w_plen == 8'd0) begin
                            n_state = crsf_pkg::ST_NOTE;
                        end else begin
                            n_mode  = crsf_pkg::MD_BYTES;
                            n_state = crsf_pkg::ST_READ;
                        end
                    end else begin
                        w_we             = 1'b1;
                        w_crc_ctrl.start = 1'b1;
                        n_state          = crsf_pkg::ST_CRC;
                    end
                end
            end
            crsf_pkg::ST_CRC: begin
                if (!w_crc_busy) begin
                    n_state = crsf_pkg::ST_GATHER;
                end
            end
            crsf_pkg::ST_FAIL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = crsf_pkg::KIND_DESYNC;
                    n_otype     = 8'd0;
                    n_oidx      = 6'd0;
                    n_oval      = 11'd0;
                    n_olast     = 1'b1;
                    n_state     = crsf_pkg::ST_SKIP;
                end
            end
            crsf_pkg::ST_NOTE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = crsf_pkg::KIND_TYPE;
                    n_otype     = r_type;
                    n_oidx      = 6'd0;
                    n_oval      = 11'd0;
                    n_olast     = 1'b1;
                    n_state     = crsf_pkg::ST_HUNT;
                end
            end
            crsf_pkg::ST_READ: begin
                n_state = crsf_pkg::ST_LOAD;
            end
            crsf_pkg::ST_LOAD: begin
                case (r_mode)
                    crsf_pkg::MD_BYTES: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_kind      = crsf_pkg::KIND_BYTE;
                            n_otype     = r_type;
                            n_oidx      = r_idx[5:0];
                            n_oval      = {3'd0, w_byte};
                            n_olast     = ((r_idx + 8'd1) == w_plen);
                            n_idx       = r_idx + 8'd1;
                            n_state     = ((r_idx + 8'd1) == w_plen) ? crsf_pkg::ST_HUNT
                                                                     : crsf_pkg::ST_READ;
                        end
                    end
                    crsf_pkg::MD_RC: begin
                        n_acc   = r_acc | (crsf_pkg::ACC_BITS'(w_byte) << r_nbits);
                        n_nbits = r_nbits + crsf_pkg::NBIT_BITS'(8);
                        n_idx   = r_idx + 8'd1;
                        n_mode  = crsf_pkg::MD_PUT;
                    end
                    crsf_pkg::MD_PUT: begin
                        if (r_nbits < crsf_pkg::NBIT_BITS'(crsf_pkg::CH_BITS)) begin
                            n_mode  = crsf_pkg::MD_RC;
                            n_state = crsf_pkg::ST_READ;
                        end else if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_kind      = crsf_pkg::KIND_CHAN;
                            n_otype     = r_type;
                            n_oidx      = {2'd0, r_ch};
                            n_oval      = r_acc[crsf_pkg::CH_BITS-1:0];
                            n_olast     = (r_ch == 4'(crsf_pkg::NUM_CH - 1));
                            n_acc       = r_acc >> crsf_pkg::CH_BITS;
                            n_nbits     = r_nbits - crsf_pkg::NBIT_BITS'(crsf_pkg::CH_BITS);
                            n_ch        = r_ch + 4'd1;
                            if (r_ch == 4'(crsf_pkg::NUM_CH - 1)) begin
                                n_state = crsf_pkg::ST_HUNT;
                            end
                        end
                    end
                    default: begin
                        n_state = crsf_pkg::ST_HUNT;
                    end
                endcase
            end
            default: begin
                n_state = crsf_pkg::ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crsf_pkg::ST_HUNT;
            r_mode      <= crsf_pkg::MD_RC;
            r_pos       <= '0;
            r_idx       <= 8'd0;
            r_ch        <= 4'd0;
            r_nbits     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_ch        <= n_ch;
            r_nbits     <= n_nbits;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_type  <= n_type;
        r_acc   <= n_acc;
        r_kind  <= n_kind;
        r_otype <= n_otype;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign o_res_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_frame_type = r_otype;
    assign o_item_index = r_oidx;
    assign o_item_value = r_oval;
    assign o_last       = r_olast;

    a_desync_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == crsf_pkg::KIND_DESYNC) |-> (o_last && o_frame_type == 8'd0))
        else $error("desync beat must be a lone final beat");

    a_chan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == crsf_pkg::KIND_CHAN) |->
        (o_item_index < 6'(crsf_pkg::NUM_CH)))
        else $error("channel index out of range");

    a_crc_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crsf_pkg::ST_GATHER && n_state == crsf_pkg::ST_CRC) |=> w_crc_busy)
        else $error("CRC unit did not start on a checked byte");

    a_acc_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbits <= crsf_pkg::NBIT_BITS'(crsf_pkg::ACC_BITS))
        else $error("channel accumulator overfilled");

endmodule

// ===== sim/crsf_frame_decoder_unit_tb.sv =====
// Self-checking testbench for the CRSF frame decoder: directed and random byte streams
// with random idle on both channels, checked against a built-in frame predictor.
// Depends on crsf_pkg and crsf_frame_decoder_unit.
`timescale 1ns / 1ps

module crsf_frame_decoder_unit_tb;

    localparam int FRAME_BYTES = 64;
    localparam int TOTAL_ITEMS = 215;
    localparam int QUIET_AFTER = 180;
    localparam logic [7:0] TYPE_FLIGHT_MODE = 8'h21;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GATHER,
        PH_SKIP
    } t_link_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_type;
        logic [5:0]  item_index;
        logic [10:0] item_value;
        logic        last;
    } t_decoded_item;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_frame_type;
    logic [5:0]  o_item_index;
    logic [10:0] o_item_value;
    logic        o_last;

    bit            quiet = 1'b0;
    int            res_hold = 0;
    int            bytes_sent = 0;
    int            err_count = 0;
    t_decoded_item expected_q[$];

    t_link_phase rx_phase;
    logic [7:0]  frame_buf [0:FRAME_BYTES-1];
    int          frame_pos;
    logic [7:0]  frame_crc;

    crsf_frame_decoder_unit #(
        .MAX_FRAME_BYTES(FRAME_BYTES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_kind       (o_kind),
        .o_frame_type (o_frame_type),
        .o_item_index (o_item_index),
        .o_item_value (o_item_value),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ crsf_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] ftype,
                               input int index, input logic [10:0] value, input bit last);
        t_decoded_item item;
        item.kind       = kind;
        item.frame_type = ftype;
        item.item_index = index[5:0];
        item.item_value = value;
        item.last       = last;
        expected_q.push_back(item);
    endtask

    task automatic push_desync();
        rx_phase  = PH_SKIP;
        frame_pos = 0;
        push_result(crsf_pkg::KIND_DESYNC, 8'h00, 0, 11'd0, 1'b1);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic        is_sync;
        logic [7:0]  ftype;
        int          plen;
        int          bit_pos;
        logic [23:0] window;
        logic [7:0]  pay [0:23];
        is_sync = (b == crsf_pkg::SYNC_MAIN) || (b == crsf_pkg::SYNC_ALT);
        case (rx_phase)
            PH_GATHER: begin
                if (frame_pos >= FRAME_BYTES) begin
                    push_desync();
                end else begin
                    frame_buf[frame_pos] = b;
                    frame_pos++;
                    if (frame_pos == 2) begin
                        if (b < 2 || b > FRAME_BYTES - 2) begin
                            push_desync();
                        end
                    end else if (frame_pos > 2) begin
                        if (frame_pos >= int'(frame_buf[1]) + 2) begin
                            if (b != frame_crc) begin
                                push_desync();
                            end else begin
                                rx_phase  = PH_HUNT;
                                frame_pos = 0;
                                ftype = frame_buf[2];
                                plen  = int'(frame_buf[1]) - 2;
                                if (ftype == crsf_pkg::TYPE_RC) begin
                                    for (int i = 0; i < 24; i++) begin
                                        pay[i] = (i < plen) ? frame_buf[3 + i] : 8'h00;
                                    end
                                    for (int k = 0; k < crsf_pkg::NUM_CH; k++) begin
                                        bit_pos = 11 * k;
                                        window  = {pay[bit_pos / 8 + 2], pay[bit_pos / 8 + 1],
                                                   pay[bit_pos / 8]};
                                        window  = window >> (bit_pos % 8);
                                        push_result(crsf_pkg::KIND_CHAN, ftype, k,
                                                    window[10:0],
                                                    k == crsf_pkg::NUM_CH - 1);
                                    end
                                end else if (ftype == crsf_pkg::TYPE_BATT ||
                                             ftype == crsf_pkg::TYPE_ATT || plen == 0) begin
                                    push_result(crsf_pkg::KIND_TYPE, ftype, 0, 11'd0, 1'b1);
                                end else begin
                                    for (int k = 0; k < plen; k++) begin
                                        push_result(crsf_pkg::KIND_BYTE, ftype, k,
                                                    {3'b000, frame_buf[3 + k]}, k == plen - 1);
                                    end
                                end
                            end
                        end else begin
                            frame_crc = crc8_next(frame_crc, b);
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (is_sync) begin
                    rx_phase = PH_HUNT;
                end
            end
            default: begin
                if (is_sync) begin
                    frame_buf[0] = crsf_pkg::SYNC_MAIN;
                    frame_pos    = 1;
                    frame_crc    = 8'h00;
                    rx_phase     = PH_GATHER;
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_decoded_item want;
        if (expected_q.size() == 0) begin
            report_error($sformatf("unexpected result beat, kind %0d type %02h index %0d",
                                   o_kind, o_frame_type, o_item_index));
            return;
        end
        want = expected_q.pop_front();
        if (o_kind !== want.kind)
            report_error($sformatf("kind %0d, expected %0d", o_kind, want.kind));
        if (o_frame_type !== want.frame_type)
            report_error($sformatf("frame_type %02h, expected %02h",
                                   o_frame_type, want.frame_type));
        if (o_item_index !== want.item_index)
            report_error($sformatf("item_index %0d, expected %0d",
                                   o_item_index, want.item_index));
        if (o_item_value !== want.item_value)
            report_error($sformatf("item_value %0d, expected %0d (index %0d)",
                                   o_item_value, want.item_value, want.item_index));
        if (o_last !== want.last)
            report_error($sformatf("last %0b, expected %0b (index %0d)",
                                   o_last, want.last, want.item_index));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_phase  = PH_HUNT;
            frame_pos = 0;
            frame_crc = 8'h00;
        end else begin
            if (i_rx_valid && !o_rx_stall) begin
                decode_byte(i_rx_byte);
            end
            if (o_res_valid && !i_res_stall) begin
                check_result();
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            res_hold    <= 0;
            i_res_stall <= 1'b0;
        end else if (res_hold != 0) begin
            res_hold <= res_hold - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_res_stall <= 1'b1;
            res_hold    <= $urandom_range(0, 2);
        end else begin
            i_res_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_rx_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] sync, input int len, input logic [7:0] ftype,
                              input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] data;
        send_byte(sync);
        send_byte(len[7:0]);
        send_byte(ftype);
        crc = crc8_next(8'h00, ftype);
        for (int k = 0; k < len - 2; k++) begin
            data = 8'($urandom_range(0, 255));
            crc  = crc8_next(crc, data);
            send_byte(data);
        end
        if (bad_crc) begin
            crc ^= 8'($urandom_range(1, 255));
        end
        send_byte(crc);
    endtask

    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_bad_length();
        send_byte(crsf_pkg::SYNC_MAIN);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(crsf_pkg::SYNC_ALT);
        send_byte(crsf_pkg::SYNC_MAIN);
        send_byte(8'h3F);
        send_byte(crsf_pkg::SYNC_MAIN);
    endtask

    task automatic test_empty_rc_frame();
        send_frame(crsf_pkg::SYNC_MAIN, 2, crsf_pkg::TYPE_RC, 1'b0);
    endtask

    task automatic test_type_notice();
        send_frame(crsf_pkg::SYNC_ALT, 3, crsf_pkg::TYPE_BATT, 1'b0);
    endtask

    task automatic test_crc_error();
        send_frame(crsf_pkg::SYNC_MAIN, 2, TYPE_FLIGHT_MODE, 1'b1);
        send_byte(crsf_pkg::SYNC_ALT);
    endtask

    task automatic test_random_frames();
        int         pick;
        int         len;
        logic [7:0] ftype;
        logic [7:0] sync;
        logic [7:0] data;
        while (bytes_sent < TOTAL_ITEMS) begin
            if (bytes_sent >= QUIET_AFTER) begin
                quiet <= 1'b1;
            end
            sync  = $urandom_range(0, 1) ? crsf_pkg::SYNC_MAIN : crsf_pkg::SYNC_ALT;
            ftype = 8'($urandom_range(0, 255));
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 62)
                                                : $urandom_range(2, 12);
            pick  = $urandom_range(0, 9);
            case (pick)
                0: begin
                    data = 8'($urandom_range(0, 255));
                    if (data == crsf_pkg::SYNC_MAIN || data == crsf_pkg::SYNC_ALT) begin
                        data ^= 8'h01;
                    end
                    send_byte(data);
                end
                1: begin
                    len = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                               : $urandom_range(FRAME_BYTES - 1, 255);
                    send_byte(sync);
                    send_byte(len[7:0]);
                    if ($urandom_range(0, 1)) begin
                        send_byte(8'($urandom_range(0, 127)));
                    end
                    send_byte(sync);
                end
                2: begin
                    send_frame(sync, len, ftype, 1'b1);
                    send_byte(sync);
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: begin
                            ftype = crsf_pkg::TYPE_RC;
                            len   = ($urandom_range(0, 2) != 0) ? 24 : $urandom_range(2, 23);
                        end
                        1: ftype = $urandom_range(0, 1) ? crsf_pkg::TYPE_BATT
                                                        : crsf_pkg::TYPE_ATT;
                        2: begin
                            ftype = TYPE_FLIGHT_MODE;
                            len   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 62)
                                                                : len;
                        end
                        default: ;
                    endcase
                    send_frame(sync, len, ftype, 1'b0);
                end
            endcase
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hunt_noise();
        test_bad_length();
        test_empty_rc_frame();
        test_type_notice();
        test_crc_error();
        test_random_frames();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived", expected_q.size()));
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
